### src/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants, register indexes, controller states and the request and
// response types of the bit-serial modular multiplier.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int WIDTH     = 32;              // exponent bits scanned per beat
  localparam int DATA_W    = 32;              // base, modulus, result width
  localparam int MOD_W     = DATA_W + 1;      // modulus with 2^DATA_W encoding
  localparam int CNT_W     = $clog2(WIDTH);
  localparam int STEP_W    = $clog2(DATA_W);
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_MODULUS  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_EXPONENT = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQR,
    ST_MUL,
    ST_HOLD
  } mexp_state_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] x;       // multiplicand, already reduced
    logic [DATA_W-1:0] y;       // scanned MSB first, any value
  } mexp_mul_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } mexp_mul_rsp_t;

endpackage

### src/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial interleaved modular multiplier: x * y mod m, one bit of y per
// cycle, MSB first. Each step forms 2r + y_i*x and folds it below m.
// ----------------------------------------------------------------------------
module mexp_mulmod (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [mexp_pkg::MOD_W-1:0] modulus,
  input  mexp_pkg::mexp_mul_req_t req,
  output mexp_pkg::mexp_mul_rsp_t rsp
);
  import mexp_pkg::*;

  logic [DATA_W-1:0] x_r;
  logic [DATA_W-1:0] y_sr_r;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [DATA_W+1:0] sum;
  logic [DATA_W+2:0] sub1;
  logic [DATA_W+2:0] sub2;

  always_comb begin
    sum  = {1'b0, acc_r, 1'b0} + (y_sr_r[DATA_W-1] ? {2'b00, x_r} : '0);
    sub1 = {1'b0, sum} - {2'b00, modulus};
    sub2 = {1'b0, sum} - {1'b0, modulus, 1'b0};
    if (!sub2[DATA_W+2]) begin
      acc_nxt = sub2[DATA_W-1:0];
    end else if (!sub1[DATA_W+2]) begin
      acc_nxt = sub1[DATA_W-1:0];
    end else begin
      acc_nxt = sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DATA_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r    <= req.x;
      y_sr_r <= req.y;
      acc_r  <= '0;
    end else if (busy_r) begin
      y_sr_r <= {y_sr_r[DATA_W-2:0], 1'b0};
      acc_r  <= acc_nxt;
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

endmodule

### src/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Square-and-multiply exponentiation: base^exponent mod modulus.
// Exponent zero goes straight to the output register with result 1;
//   otherwise WIDTH squarings plus one multiplication per set exponent bit,
//   each product run by the bit-serial multiplier (32 steps plus load and unload).
// Throughput: one beat at a time; the next beat is taken once the result
//   moves into the output register. Sync reset: modulus 1, exponent 1, idle.
// ----------------------------------------------------------------------------
module modular_exponentiation (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [mexp_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [mexp_pkg::DATA_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mexp_pkg::DATA_W-1:0]        in_base,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mexp_pkg::DATA_W-1:0]        out_power_mod
);
  import mexp_pkg::*;

  logic [DATA_W-1:0] modulus_r;
  logic [DATA_W-1:0] exponent_r;

  mexp_state_t       state_r, state_nxt;
  logic [DATA_W-1:0] base_r;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0]  exp_sr_r, exp_sr_nxt;
  logic [CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic              go_r, go_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r;

  logic [MOD_W-1:0]        mod_w;
  logic [WIDTH+DATA_W-1:0] exp_ext;
  logic [WIDTH-1:0]        exp_w;
  logic                    in_fire;
  logic                    out_free;
  logic                    last_bit;
  mexp_mul_req_t           mul_req;
  mexp_mul_rsp_t           mul_rsp;

  // zero modulus stands for 2^DATA_W
  assign mod_w    = {modulus_r == '0, modulus_r};
  assign exp_ext  = {{WIDTH{1'b0}}, exponent_r};
  assign exp_w    = exp_ext[WIDTH-1:0];
  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign last_bit = (bit_cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= DATA_W'(1);
      exponent_r <= DATA_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MODULUS:  modulus_r  <= cfg_wdata;
        REG_EXPONENT: exponent_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (exp_w == '0) ? ST_HOLD : ST_SQR;
        end
      end
      ST_SQR: begin
        if (mul_rsp.done) begin
          if (exp_sr_r[WIDTH-1]) begin
            state_nxt = ST_MUL;
          end else if (last_bit) begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_MUL: begin
        if (mul_rsp.done) begin
          state_nxt = last_bit ? ST_HOLD : ST_SQR;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    acc_nxt       = acc_r;
    exp_sr_nxt    = exp_sr_r;
    bit_cnt_nxt   = bit_cnt_r;
    go_nxt        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          exp_sr_nxt  = exp_w;
          bit_cnt_nxt = CNT_W'(WIDTH - 1);
          if (exp_w == '0) begin
            acc_nxt = DATA_W'(1);
          end else begin
            acc_nxt = (mod_w == MOD_W'(1)) ? '0 : DATA_W'(1);
            go_nxt  = 1'b1;
          end
        end
      end
      ST_SQR, ST_MUL: begin
        if (mul_rsp.done) begin
          acc_nxt = mul_rsp.result;
          if (state_r == ST_SQR && exp_sr_r[WIDTH-1]) begin
            go_nxt = 1'b1;
          end else if (!last_bit) begin
            exp_sr_nxt  = {exp_sr_r[WIDTH-2:0], 1'b0};
            bit_cnt_nxt = bit_cnt_r - 1'b1;
            go_nxt      = 1'b1;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    exp_sr_r <= exp_sr_nxt;
    if (in_fire) begin
      base_r <= in_base;
    end
    if (state_r == ST_HOLD && out_free) begin
      out_data_r <= acc_r;
    end
  end

  assign mul_req.start = go_r;
  assign mul_req.x     = acc_r;
  assign mul_req.y     = (state_r == ST_MUL) ? base_r : acc_r;

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .modulus (mod_w),
    .req     (mul_req),
    .rsp     (mul_rsp)
  );

  assign out_valid     = out_valid_r;
  assign out_power_mod = out_data_r;

endmodule

### src/mexp_chk.sv
// ----------------------------------------------------------------------------
// mexp_chk
// Port-level checks for modular_exponentiation, bound to the top level.
// ----------------------------------------------------------------------------
module mexp_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [mexp_pkg::DATA_W-1:0] out_power_mod
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_power_mod)))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat taken while first is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a beat in work");

endmodule

bind modular_exponentiation mexp_chk u_mexp_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_power_mod (out_power_mod)
);
